/* src/cflr_pkg.sv */
// ============================================================================
// cflr_pkg: shared types and constants of the framed link receiver
// Phase and sequencer codes, result kinds, register indexes, CRC-8 step.
// ============================================================================
`default_nettype none

package cflr_pkg;

  localparam int DEF_MAX_PAYLOAD = 32;

  localparam logic [7:0] START_BYTE    = 8'hA5;
  localparam logic [7:0] CRC_POLY      = 8'h07;
  localparam logic [7:0] CRC_MSB       = 8'h80;
  localparam logic [7:0] ACK_LEN_BYTE  = 8'h03;
  localparam logic [7:0] LAST_ID_RESET = 8'hFF;

  localparam logic [7:0] HELLO_CODE_RESET = 8'd1;
  localparam logic [7:0] ACK_CODE_RESET   = 8'd2;
  localparam logic [7:0] DATA_CODE_RESET  = 8'd3;

  localparam int CFG_AW = 4;

  // Register indexes (word address)
  localparam logic [1:0] REG_HELLO = 2'd0;
  localparam logic [1:0] REG_ACK   = 2'd1;
  localparam logic [1:0] REG_DATA  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_PAY   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } rx_phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_ACK,
    SQ_READ,
    SQ_PAY,
    SQ_EMPTY
  } seq_state_t;

  // Descriptor of a frame that passed its CRC check
  typedef struct packed {
    logic       start;
    logic       ack_en;
    logic       dlv_en;
    logic [7:0] msg_id;
    logic [7:0] ftype;
    logic [5:0] pay;
    logic [7:0] ack_code;
    logic [7:0] remote_id;
    logic       remote_known;
  } frame_desc_t;

  // One byte of CRC-8, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] v);
    logic [7:0] c;
    c = acc ^ v;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/cflr_out_seq.sv */
// ============================================================================
// cflr_out_seq: result sequencer
// Emits the ACK frame and/or the payload or empty marker of one good frame
// through a registered output stage, reading payload bytes from body memory.
// ============================================================================
`default_nettype none

module cflr_out_seq #(
  parameter int MEM_AW = 6
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire cflr_pkg::frame_desc_t desc,
  output logic                  idle,
  output logic                  rd_en,
  output logic [MEM_AW-1:0]     rd_addr,
  input  wire  [7:0]            rd_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_data_byte,
  output logic [7:0]            out_frame_msg_id,
  output logic [7:0]            out_frame_type,
  output logic [5:0]            out_payload_count,
  output logic                  out_last,
  output logic [7:0]            out_remote_id,
  output logic                  out_remote_known
);
  import cflr_pkg::*;

  seq_state_t  state_r, state_nxt;
  frame_desc_t fd_r;
  logic [2:0]  idx_r;
  logic [5:0]  k_r;
  logic [7:0]  ack_crc_r;

  logic        slot_free;
  logic        ld;
  logic [1:0]  ld_kind;
  logic [7:0]  ld_byte;
  logic        ld_last;
  logic [7:0]  ack_byte;
  logic        pay_last;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_byte_r;
  logic [7:0]  out_id_r;
  logic [7:0]  out_type_r;
  logic [5:0]  out_cnt_r;
  logic        out_last_r;
  logic [7:0]  out_rid_r;
  logic        out_rknown_r;

  assign slot_free = !out_valid_r || out_ready;
  assign pay_last  = (k_r == (fd_r.pay - 6'd1));
  assign rd_addr   = MEM_AW'({1'b0, k_r} + 7'd2);
  assign idle      = (state_r == SQ_IDLE);

  always_comb begin
    case (idx_r)
      3'd0:    ack_byte = START_BYTE;
      3'd1:    ack_byte = ACK_LEN_BYTE;
      3'd2:    ack_byte = fd_r.ack_code;
      3'd3:    ack_byte = fd_r.msg_id;
      default: ack_byte = ack_crc_r;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_IDLE: begin
        if (desc.start) begin
          if (desc.ack_en) begin
            state_nxt = SQ_ACK;
          end else if (desc.pay == 6'd0) begin
            state_nxt = SQ_EMPTY;
          end else begin
            state_nxt = SQ_READ;
          end
        end
      end
      SQ_ACK: begin
        if (slot_free && idx_r == 3'd4) begin
          if (!fd_r.dlv_en) begin
            state_nxt = SQ_IDLE;
          end else if (fd_r.pay == 6'd0) begin
            state_nxt = SQ_EMPTY;
          end else begin
            state_nxt = SQ_READ;
          end
        end
      end
      SQ_READ: state_nxt = SQ_PAY;
      SQ_PAY: begin
        if (slot_free) begin
          state_nxt = pay_last ? SQ_IDLE : SQ_READ;
        end
      end
      SQ_EMPTY: begin
        if (slot_free) begin
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ld      = 1'b0;
    ld_kind = KIND_ACK;
    ld_byte = 8'h00;
    ld_last = 1'b0;
    rd_en   = 1'b0;
    case (state_r)
      SQ_ACK: begin
        ld      = slot_free;
        ld_kind = KIND_ACK;
        ld_byte = ack_byte;
        ld_last = (idx_r == 3'd4) && !fd_r.dlv_en;
      end
      SQ_READ: rd_en = 1'b1;
      SQ_PAY: begin
        ld      = slot_free;
        ld_kind = KIND_PAY;
        ld_byte = rd_data;
        ld_last = pay_last;
      end
      SQ_EMPTY: begin
        ld      = slot_free;
        ld_kind = KIND_EMPTY;
        ld_last = 1'b1;
      end
      default: ld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Frame descriptor, ACK byte index, payload index, ACK checksum
  always_ff @(posedge clk) begin
    if (state_r == SQ_IDLE && desc.start) begin
      fd_r      <= desc;
      idx_r     <= 3'd0;
      k_r       <= 6'd0;
      ack_crc_r <= 8'h00;
    end else begin
      if (state_r == SQ_ACK && ld) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r != 3'd0 && idx_r != 3'd4) begin
          ack_crc_r <= crc8_step(ack_crc_r, ack_byte);
        end
      end
      if (state_r == SQ_PAY && ld) begin
        k_r <= k_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_kind_r   <= ld_kind;
      out_byte_r   <= ld_byte;
      out_id_r     <= fd_r.msg_id;
      out_type_r   <= fd_r.ftype;
      out_cnt_r    <= fd_r.pay;
      out_last_r   <= ld_last;
      out_rid_r    <= fd_r.remote_id;
      out_rknown_r <= fd_r.remote_known;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_data_byte     = out_byte_r;
  assign out_frame_msg_id  = out_id_r;
  assign out_frame_type    = out_type_r;
  assign out_payload_count = out_cnt_r;
  assign out_last          = out_last_r;
  assign out_remote_id     = out_rid_r;
  assign out_remote_known  = out_rknown_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    desc.start |-> (state_r == SQ_IDLE))
    else $error("frame start while sequencer busy");

  a_read_then_pay: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == SQ_PAY))
    else $error("memory read not followed by payload step");

  a_ack_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_ACK) |-> (idx_r <= 3'd4))
    else $error("ACK byte index out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && ld_last) |=> (state_r == SQ_IDLE))
    else $error("sequencer still busy after final result");
`endif

endmodule

`default_nettype wire

/* src/crc8_framed_link_receiver.sv */
// ============================================================================
// crc8_framed_link_receiver: framed byte-link receiver with CRC-8 check
// Hunts for start byte, buffers the frame body, checks CRC-8 and emits an
// ACK frame plus the delivered payload.
// ============================================================================
// Usage:
//  - in_* channel: one received line byte per item (valid/ready).
//  - out_* channel: result items (valid/ready) through an output register;
//    kind tells ACK byte to transmit, payload byte, or empty-frame marker;
//    out_last marks the final result caused by one input byte.
//  - cfg_* port: APB-style; HELLO, ACK and DATA type codes at 0x0, 0x4, 0x8.
//  - A byte that does not end a frame causes no result;
//    in_ready stays high, also while an older result waits in the output
//    register.
//  - The byte that ends a good frame starts the result sequencer: five ACK
//    bytes (none for an ACK frame) at one per cycle unless out_ready stalls,
//    then per payload byte one body memory read and one load of the output
//    register (or one empty-frame marker); in_ready is low until the last
//    result is loaded. CRC over length and body accumulates as bytes arrive.
//  - A stalled receiver freezes the sequencer; nothing is dropped.
//  - Reset (rst_n, synchronous) returns to start-byte hunt and restores the
//    register defaults; the body memory needs no clearing.
// ============================================================================
`default_nettype none

module crc8_framed_link_receiver #(
  parameter int MAX_PAYLOAD = cflr_pkg::DEF_MAX_PAYLOAD
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Received bytes
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [7:0]                   in_rx_byte,
  // Results
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_kind,
  output logic [7:0]                   out_data_byte,
  output logic [7:0]                   out_frame_msg_id,
  output logic [7:0]                   out_frame_type,
  output logic [5:0]                   out_payload_count,
  output logic                         out_last,
  output logic [7:0]                   out_remote_id,
  output logic                         out_remote_known,
  // Configuration
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [cflr_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire  [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import cflr_pkg::*;

  localparam int         MEM_DEPTH = MAX_PAYLOAD + 3;
  localparam int         MEM_AW    = $clog2(MEM_DEPTH);
  localparam logic [7:0] LEN_MIN   = 8'd3;
  localparam logic [7:0] LEN_MAX   = 8'(MEM_DEPTH);

  // Configuration registers
  logic [7:0] hello_code_r;
  logic [7:0] ack_code_r;
  logic [7:0] data_code_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // Frame parser state
  rx_phase_t  phase_r, phase_nxt;
  logic [7:0] exp_len_r, exp_len_nxt;
  logic [5:0] body_idx_r, body_idx_nxt;
  logic [5:0] idx_inc;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] ty_r, ty_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] p0_r, p0_nxt;
  logic [7:0] last_id_r, last_id_nxt;
  logic [7:0] rid_r, rid_nxt;
  logic       rknown_r, rknown_nxt;

  logic        acc;
  logic        finish;
  logic        dup;
  logic [5:0]  pay;
  logic        mem_we;
  frame_desc_t desc;

  // Body memory
  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rd_data_r;
  logic              rd_en;
  logic [MEM_AW-1:0] rd_addr;
  logic              seq_idle;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hello_code_r <= HELLO_CODE_RESET;
      ack_code_r   <= ACK_CODE_RESET;
      data_code_r  <= DATA_CODE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HELLO: hello_code_r <= cfg_pwdata[7:0];
        REG_ACK:   ack_code_r   <= cfg_pwdata[7:0];
        REG_DATA:  data_code_r  <= cfg_pwdata[7:0];
        default:   hello_code_r <= hello_code_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HELLO: cfg_prdata = {24'h0, hello_code_r};
      REG_ACK:   cfg_prdata = {24'h0, ack_code_r};
      REG_DATA:  cfg_prdata = {24'h0, data_code_r};
      default:   cfg_prdata = 32'h0;
    endcase
  end

  // ---------------- frame parser ----------------
  // Hold input while the sequencer emits results of a finished frame.
  assign in_ready = seq_idle;
  assign acc      = in_valid && in_ready;
  assign idx_inc  = body_idx_r + 6'd1;
  assign pay      = 6'(exp_len_r - LEN_MIN);

  always_comb begin
    phase_nxt    = phase_r;
    exp_len_nxt  = exp_len_r;
    body_idx_nxt = body_idx_r;
    crc_nxt      = crc_r;
    ty_nxt       = ty_r;
    id_nxt       = id_r;
    p0_nxt       = p0_r;
    finish       = 1'b0;
    mem_we       = 1'b0;
    if (acc) begin
      case (phase_r)
        PH_LENGTH: begin
          exp_len_nxt = in_rx_byte;
          if (in_rx_byte < LEN_MIN || in_rx_byte > LEN_MAX) begin
            phase_nxt = PH_START;
          end else begin
            body_idx_nxt = 6'd0;
            crc_nxt      = crc8_step(8'h00, in_rx_byte);
            phase_nxt    = PH_BODY;
          end
        end
        PH_BODY: begin
          mem_we       = 1'b1;
          body_idx_nxt = idx_inc;
          // Keep type, id and first payload byte at hand for frame end
          if (body_idx_r == 6'd0) ty_nxt = in_rx_byte;
          if (body_idx_r == 6'd1) id_nxt = in_rx_byte;
          if (body_idx_r == 6'd2) p0_nxt = in_rx_byte;
          if ({2'b00, idx_inc} >= exp_len_r) begin
            finish    = 1'b1;
            phase_nxt = PH_START;
          end else begin
            // Every body byte but the trailing CRC enters the checksum
            crc_nxt = crc8_step(crc_r, in_rx_byte);
          end
        end
        default: begin
          phase_nxt = (in_rx_byte == START_BYTE) ? PH_LENGTH : PH_START;
        end
      endcase
    end
  end

  // Frame end: check CRC, learn remote id, filter duplicate DATA.
  always_comb begin
    last_id_nxt = last_id_r;
    rid_nxt     = rid_r;
    rknown_nxt  = rknown_r;
    dup         = 1'b0;
    desc        = '0;
    if (finish && crc_r == in_rx_byte) begin
      if (ty_r == hello_code_r && pay != 6'd0) begin
        rid_nxt    = p0_r;
        rknown_nxt = 1'b1;
      end
      if (ty_r == data_code_r) begin
        if (id_r == last_id_r) begin
          dup = 1'b1;
        end else begin
          last_id_nxt = id_r;
        end
      end
      desc.ack_en       = (ty_r != ack_code_r);
      desc.dlv_en       = !dup;
      desc.start        = desc.ack_en || desc.dlv_en;
      desc.msg_id       = id_r;
      desc.ftype        = ty_r;
      desc.pay          = pay;
      desc.ack_code     = ack_code_r;
      desc.remote_id    = rid_nxt;
      desc.remote_known = rknown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      exp_len_r  <= 8'h00;
      body_idx_r <= 6'd0;
      last_id_r  <= LAST_ID_RESET;
      rid_r      <= 8'h00;
      rknown_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      exp_len_r  <= exp_len_nxt;
      body_idx_r <= body_idx_nxt;
      last_id_r  <= last_id_nxt;
      rid_r      <= rid_nxt;
      rknown_r   <= rknown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    ty_r  <= ty_nxt;
    id_r  <= id_nxt;
    p0_r  <= p0_nxt;
  end

  // ---------------- body memory ----------------
  // Writes come only with accepted bytes and reads only while the input is
  // held, so the two ports never touch the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[body_idx_r[MEM_AW-1:0]] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // ---------------- result sequencer ----------------
  cflr_out_seq #(
    .MEM_AW (MEM_AW)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .desc              (desc),
    .idle              (seq_idle),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_frame_msg_id  (out_frame_msg_id),
    .out_frame_type    (out_frame_type),
    .out_payload_count (out_payload_count),
    .out_last          (out_last),
    .out_remote_id     (out_remote_id),
    .out_remote_known  (out_remote_known)
  );

endmodule

`default_nettype wire
